// ===== src/swm_pkg.sv =====
package swm_pkg;

  localparam int DATA_W          = 32;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int CMDQ_DEPTH      = 2;

  typedef enum logic [1:0] {
    OP_PUSH_L = 2'd0,
    OP_PUSH_R = 2'd1,
    OP_END_L  = 2'd2,
    OP_END_R  = 2'd3
  } op_e;

  // Decoded transaction handed from the front to the merge engine
  typedef struct packed {
    logic              push;   // 1: push value, 0: end-of-stream marker
    logic              side;   // 0: left, 1: right
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP
  } state_e;

endpackage

// ===== src/swm_front.sv =====
module swm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [swm_pkg::DATA_W-1:0]    in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output swm_pkg::cmd_t                 cmd
);

  localparam int PW = $clog2(swm_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(swm_pkg::CMDQ_DEPTH + 1);

  swm_pkg::cmd_t q_r [swm_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  swm_pkg::cmd_t in_cmd;
  swm_pkg::op_e  op;
  logic          wr_en;
  logic          rd_en;

  always_comb begin
    op           = swm_pkg::op_e'(in_tuser);
    in_cmd.push  = (op inside {swm_pkg::OP_PUSH_L, swm_pkg::OP_PUSH_R});
    in_cmd.side  = (op inside {swm_pkg::OP_PUSH_R, swm_pkg::OP_END_R});
    in_cmd.value = in_tdata;
  end

  assign in_tready = (cnt_r != CW'(swm_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = in_tvalid && in_tready;
  assign rd_en     = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(swm_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(swm_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== src/swm_back.sv =====
module swm_back #(
  parameter int QUEUE_DEPTH = swm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  swm_pkg::cmd_t                 cmd,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [swm_pkg::DATA_W-1:0]    out_tdata,
  output logic [2:0]                    out_tuser,
  output logic                          out_tlast
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(swm_pkg::MAX_RESULTS + 1);
  localparam int DW = swm_pkg::DATA_W;

  logic [DW-1:0] l_mem [QUEUE_DEPTH];
  logic [DW-1:0] r_mem [QUEUE_DEPTH];

  swm_pkg::state_e state_r, state_nxt;
  logic [PW-1:0]   l_head_r, l_tail_r, r_head_r, r_tail_r;
  logic [CW-1:0]   l_cnt_r, r_cnt_r;
  logic            l_end_r, r_end_r, drop_r;
  logic [NW-1:0]   n_r;
  logic [DW-1:0]   l_rd_r, r_rd_r;

  logic            out_valid_r;
  logic [DW-1:0]   out_data_r;
  logic [2:0]      out_user_r;
  logic            out_last_r;

  logic            l_ne, r_ne, can_take, take_left, more, done_now, done_after;
  logic [CW-1:0]   l_cnt_a, r_cnt_a;
  logic            out_space;
  logic            accept, l_full, r_full, l_wr, r_wr;
  logic            emit, pop_l, pop_r;
  logic            emit_has, emit_fin, emit_last;
  logic [DW-1:0]   emit_val;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign l_ne      = (l_cnt_r != '0);
  assign r_ne      = (r_cnt_r != '0);
  assign can_take  = (l_ne && r_ne) || (l_ne && r_end_r) || (r_ne && l_end_r);
  assign take_left = (l_ne && r_ne) ? ($signed(l_rd_r) <= $signed(r_rd_r)) : l_ne;
  assign l_cnt_a   = l_cnt_r - CW'(take_left);
  assign r_cnt_a   = r_cnt_r - CW'(!take_left);
  // Whether another element can follow depends on the result count, occupancy and end flags
  assign more      = ((NW'(n_r) + 1'b1) < NW'(swm_pkg::MAX_RESULTS)) &&
                     (((l_cnt_a != '0) && (r_cnt_a != '0)) ||
                      ((l_cnt_a != '0) && r_end_r) || ((r_cnt_a != '0) && l_end_r));
  assign done_now   = l_end_r && r_end_r && !l_ne && !r_ne;
  assign done_after = l_end_r && r_end_r && (l_cnt_a == '0) && (r_cnt_a == '0);
  assign out_space  = !out_valid_r || out_tready;
  assign l_full     = (l_cnt_r == CW'(QUEUE_DEPTH));
  assign r_full     = (r_cnt_r == CW'(QUEUE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swm_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = swm_pkg::ST_RD;
        end
      end
      swm_pkg::ST_RD: begin
        state_nxt = swm_pkg::ST_CMP;
      end
      swm_pkg::ST_CMP: begin
        if (can_take) begin
          if (out_space) begin
            state_nxt = more ? swm_pkg::ST_RD : swm_pkg::ST_IDLE;
          end
        end else if (drop_r || done_now) begin
          if (out_space) begin
            state_nxt = swm_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    accept    = 1'b0;
    l_wr      = 1'b0;
    r_wr      = 1'b0;
    emit      = 1'b0;
    pop_l     = 1'b0;
    pop_r     = 1'b0;
    emit_has  = 1'b0;
    emit_val  = '0;
    emit_fin  = 1'b0;
    emit_last = 1'b1;
    case (state_r)
      swm_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        accept    = cmd_valid;
        l_wr      = cmd_valid && cmd.push && !cmd.side && !l_full;
        r_wr      = cmd_valid && cmd.push && cmd.side && !r_full;
      end
      swm_pkg::ST_CMP: begin
        if (can_take) begin
          emit      = out_space;
          pop_l     = out_space && take_left;
          pop_r     = out_space && !take_left;
          emit_has  = 1'b1;
          emit_val  = take_left ? l_rd_r : r_rd_r;
          emit_fin  = !more && done_after;
          emit_last = !more;
        end else if (drop_r || done_now) begin
          emit     = out_space;
          emit_fin = done_now;
        end
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= swm_pkg::ST_IDLE;
      l_head_r <= '0;
      l_tail_r <= '0;
      r_head_r <= '0;
      r_tail_r <= '0;
      l_cnt_r  <= '0;
      r_cnt_r  <= '0;
      l_end_r  <= 1'b0;
      r_end_r  <= 1'b0;
      drop_r   <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        n_r    <= '0;
        drop_r <= cmd.push && (cmd.side ? r_full : l_full);
        if (!cmd.push && !cmd.side) begin
          l_end_r <= 1'b1;
        end
        if (!cmd.push && cmd.side) begin
          r_end_r <= 1'b1;
        end
      end
      if (l_wr) begin
        l_tail_r <= ptr_inc(l_tail_r);
        l_cnt_r  <= l_cnt_r + 1'b1;
      end
      if (r_wr) begin
        r_tail_r <= ptr_inc(r_tail_r);
        r_cnt_r  <= r_cnt_r + 1'b1;
      end
      if (pop_l) begin
        l_head_r <= ptr_inc(l_head_r);
        l_cnt_r  <= l_cnt_r - 1'b1;
      end
      if (pop_r) begin
        r_head_r <= ptr_inc(r_head_r);
        r_cnt_r  <= r_cnt_r - 1'b1;
      end
      if (pop_l || pop_r) begin
        n_r <= n_r + 1'b1;
      end
    end
  end

  // Queue memories: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (l_wr) begin
      l_mem[l_tail_r] <= cmd.value;
    end
    l_rd_r <= l_mem[l_head_r];
  end

  always_ff @(posedge clk) begin
    if (r_wr) begin
      r_mem[r_tail_r] <= cmd.value;
    end
    r_rd_r <= r_mem[r_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_val;
      out_user_r <= {emit_fin, drop_r, emit_has};
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/two_way_sorted_stream_merge_core.sv =====
// Two-way merge node: merges two ascending signed 32-bit streams into one
// ascending stream, left first on ties. in_tuser selects push-left, push-right,
// left-ended or right-ended; a push into a full queue is discarded and flagged.
// A two-entry input queue takes transactions while the merge engine works. The
// engine handles one transaction at a time and emits n elements for it (at most
// 16): every element takes a registered read of the queue memory heads, then a
// compare and emit; a stalled output holds the compare.
// After both ends, the final element carries finished; with nothing left to
// emit, one empty result with finished (or dropped) and tlast is given.
module two_way_sorted_stream_merge_core #(
  parameter int QUEUE_DEPTH = swm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [swm_pkg::DATA_W-1:0]    in_tdata,   // [31:0] value
  input  logic [1:0]                    in_tuser,   // [1:0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [swm_pkg::DATA_W-1:0]    out_tdata,  // [31:0] merged_value
  output logic [2:0]                    out_tuser,  // [0] has_value, [1] dropped, [2] finished
  output logic                          out_tlast
);

  logic          cmd_valid;
  logic          cmd_ready;
  swm_pkg::cmd_t cmd;

  swm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  swm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/swm_checker.sv =====
module swm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [swm_pkg::DATA_W-1:0]    out_tdata,
  input logic [2:0]                    out_tuser,
  input logic                          out_tlast
);

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output transaction changed");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("empty result not last or carries data");

  a_finished_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("finished flag on a non-final result");

  a_empty_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] || out_tuser[2])
    else $error("empty result without drop or finish");

endmodule

bind two_way_sorted_stream_merge_core swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
